// ----- sv/pco_pkg.sv -----
// ----------------------------------------------------------------------------
// pco_pkg
// shared types and constants of the phase continuous tone oscillator
// ----------------------------------------------------------------------------
`default_nettype none

package pco_pkg;

  // field widths of the item ports
  localparam int unsigned StepW = 31;
  localparam int unsigned AmpW  = 16;

  // angle handed to the rotator, turns scaled by 2^32
  localparam int unsigned TurnW = 32;

  // rotator datapath: x and y in Q2.30 with headroom, angle with one guard bit
  localparam int unsigned XyW  = 34;
  localparam int unsigned AngW = 33;

  // infinite-stage rotation gain in Q2.30
  localparam logic signed [XyW-1:0] CordicGain = 34'sd652032874;

  // arctangent of 2^-i in 2^-32 turns, rounded to nearest
  localparam int unsigned AtanLen = 24;
  localparam logic [TurnW-1:0] AtanTable [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // state handed from one rotator cell to the next
  typedef struct packed {
    logic signed [XyW-1:0]  x;
    logic signed [XyW-1:0]  y;
    logic signed [AngW-1:0] a;
    logic [AmpW-1:0]        amp;
  } pco_vec_t;

endpackage

`default_nettype wire

// ----- sv/pco_cell.sv -----
// ----------------------------------------------------------------------------
// pco_cell
// one rotation micro-step with its own pipeline register
// ----------------------------------------------------------------------------
`default_nettype none

module pco_cell
  import pco_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  pco_vec_t vec_i,
  output logic     valid_o,
  input  logic     ready_i,
  output pco_vec_t vec_o
);

  localparam logic signed [AngW-1:0] Angle = $signed({1'b0, AtanTable[SHIFT]});

  logic                  valid_q;
  pco_vec_t              vec_q, vec_d;
  logic signed [XyW-1:0] xs, ys;
  logic                  rot_pos;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign vec_o   = vec_q;

  always_comb begin
    xs      = $signed(vec_i.x) >>> SHIFT;
    ys      = $signed(vec_i.y) >>> SHIFT;
    rot_pos = !vec_i.a[AngW-1];
    vec_d   = vec_i;
    if (rot_pos) begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.a = vec_i.a - Angle;
    end else begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.a = vec_i.a + Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      vec_q <= vec_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pco_scale.sv -----
// ----------------------------------------------------------------------------
// pco_scale
// sine rounding, amplitude multiply and saturation, three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module pco_scale
  import pco_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [XyW-1:0]         y_i,
  input  logic [AmpW-1:0]               amp_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned Sh    = 31 - SAMPLE_BITS;
  localparam int unsigned SineW = SAMPLE_BITS + 2;
  localparam int unsigned ProdW = SineW + AmpW + 1;

  localparam logic signed [XyW-1:0]   SineRnd = XyW'(1) <<< (Sh - 1);
  localparam logic signed [ProdW-1:0] ProdRnd = ProdW'(1) <<< 14;
  localparam logic signed [ProdW-1:0] SMax    = (ProdW'(1) <<< (SAMPLE_BITS - 1)) - ProdW'(1);
  localparam logic signed [ProdW-1:0] SMin    = -(ProdW'(1) <<< (SAMPLE_BITS - 1));

  logic                          rnd_valid_q, mul_valid_q, out_valid_q;
  logic                          rnd_ready, mul_ready, out_ready;
  logic signed [SineW-1:0]       sine_q;
  logic [AmpW-1:0]               amp_q;
  logic signed [ProdW-1:0]       prod_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  logic signed [XyW-1:0]   y_rnd, y_sh;
  logic signed [ProdW-1:0] res;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign out_ready = !out_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || out_ready;
  assign rnd_ready = !rnd_valid_q || mul_ready;
  assign ready_o   = rnd_ready;
  assign valid_o   = out_valid_q;
  assign sample_o  = sample_q;

  // round half up to the sample grid
  always_comb begin
    y_rnd = y_i + SineRnd;
    y_sh  = y_rnd >>> Sh;
  end

  // round the product, then clamp to the sample range
  always_comb begin
    res = (prod_q + ProdRnd) >>> 15;
    if (res > SMax) begin
      sat = SMax[SAMPLE_BITS-1:0];
    end else if (res < SMin) begin
      sat = SMin[SAMPLE_BITS-1:0];
    end else begin
      sat = res[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rnd_ready) begin
        rnd_valid_q <= valid_i;
      end
      if (mul_ready) begin
        mul_valid_q <= rnd_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rnd_ready) begin
      sine_q <= y_sh[SineW-1:0];
      amp_q  <= amp_i;
    end
    if (rnd_valid_q && mul_ready) begin
      prod_q <= $signed({1'b0, amp_q}) * sine_q;
    end
    if (mul_valid_q && out_ready) begin
      sample_q <= sat;
    end
  end

endmodule

`default_nettype wire

// ----- sv/phase_continuous_tone_oscillator.sv -----
// ----------------------------------------------------------------------------
// phase_continuous_tone_oscillator
// sine tone generator with a phase accumulator that runs across tone changes
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with phase_step_i and
//   tone_amplitude_i, one item per sample tick. output channel:
//   out_valid_o / out_stall_i with sample_o, exactly one item per input item
//   - each item produces amplitude * sin(phase) and then moves the phase
//     on by the step, modulo one turn; a new tone keeps the running phase
//   - pipeline: 1 fold stage + min(CORDIC_STAGES, 24) rotator cells + 3
//     scaling stages
//   - throughput: one item per cycle unless the receiver stalls; every stage
//     register has its own valid bit, so items follow in consecutive cycles
//   - stall: when the receiver stalls, items pile up in empty stages first;
//     in_stall_o rises only when every stage back to the fold is full
//   - reset clears the phase accumulator and all valid bits; no item is in
//     flight after reset
// ----------------------------------------------------------------------------
`default_nettype none

module phase_continuous_tone_oscillator
  import pco_pkg::*;
#(
  parameter int unsigned PHASE_BITS    = 32,
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [StepW-1:0]              phase_step_i,
  input  logic [AmpW-1:0]               tone_amplitude_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  // rotator length is bounded by the arctangent table
  localparam int unsigned Stages = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;

  localparam logic signed [AngW-1:0] QuarterTurn = 33'sd1073741824;
  localparam logic signed [AngW-1:0] HalfTurn    = 33'sd2147483648;

  // phase accumulator
  logic [PHASE_BITS-1:0] acc_q, acc_d;
  logic [PHASE_BITS-1:0] step_scaled;
  logic [TurnW-1:0]      turn;
  logic                  in_accept;

  // fold stage
  logic                  fold_valid_q;
  logic                  fold_ready;
  logic signed [AngW-1:0] fold_a_q, fold_a_d, a_ext;
  logic [AmpW-1:0]       fold_amp_q;

  // rotator chain, index 0 is the fold stage output
  logic     cell_valid [Stages+1];
  logic     cell_ready [Stages+1];
  pco_vec_t cell_vec   [Stages+1];

  // align step and angle to the accumulator width
  generate
    if (PHASE_BITS > TurnW) begin : g_wide
      assign turn        = acc_q[PHASE_BITS-1 -: TurnW];
      assign step_scaled = {1'b0, phase_step_i, {(PHASE_BITS - TurnW){1'b0}}};
    end else if (PHASE_BITS == TurnW) begin : g_equal
      assign turn        = acc_q;
      assign step_scaled = {1'b0, phase_step_i};
    end else begin : g_narrow
      assign turn        = {acc_q, {(TurnW - PHASE_BITS){1'b0}}};
      assign step_scaled = {1'b0, phase_step_i[StepW-1 -: (PHASE_BITS - 1)]};
    end
  endgenerate

  assign in_accept  = in_valid_i && !in_stall_o;
  assign fold_ready = !fold_valid_q || cell_ready[0];
  assign in_stall_o = !fold_ready;
  assign acc_d      = acc_q + step_scaled;

  // fold the angle into the right half plane, sin(1/2 - a) = sin(a)
  always_comb begin
    a_ext = {turn[TurnW-1], turn};
    if (a_ext > QuarterTurn) begin
      fold_a_d = HalfTurn - a_ext;
    end else if (a_ext < -QuarterTurn) begin
      fold_a_d = -HalfTurn - a_ext;
    end else begin
      fold_a_d = a_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      fold_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        acc_q <= acc_d;
      end
      if (fold_ready) begin
        fold_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fold_a_q   <= fold_a_d;
      fold_amp_q <= tone_amplitude_i;
    end
  end

  // rotator starts from the gain-compensated unit vector
  assign cell_valid[0] = fold_valid_q;
  assign cell_vec[0]   = '{x: CordicGain, y: '0, a: fold_a_q, amp: fold_amp_q};

  generate
    for (genvar k = 0; k < Stages; k++) begin : g_cell
      pco_cell #(
        .SHIFT (k)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (cell_valid[k]),
        .ready_o (cell_ready[k]),
        .vec_i   (cell_vec[k]),
        .valid_o (cell_valid[k+1]),
        .ready_i (cell_ready[k+1]),
        .vec_o   (cell_vec[k+1])
      );
    end
  endgenerate

  pco_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cell_valid[Stages]),
    .ready_o  (cell_ready[Stages]),
    .y_i      (cell_vec[Stages].y),
    .amp_i    (cell_vec[Stages].amp),
    .valid_o  (out_valid_o),
    .ready_i  (!out_stall_i),
    .sample_o (sample_o)
  );

  // the phase moves only with an accepted item
  a_acc_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(acc_q))
    else $error("phase accumulator changed without an accepted item");

  // an accepted item advances the phase by the scaled step
  a_acc_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> acc_q == $past(acc_d))
    else $error("phase accumulator did not advance by the step");

  // back pressure on the input only comes from a stalled output
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output drains");

  // folded angle stays within a quarter turn
  a_fold_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_valid_q |-> (fold_a_q <= QuarterTurn && fold_a_q >= -QuarterTurn))
    else $error("folded angle outside a quarter turn");

endmodule

`default_nettype wire

// ----- test/pco_sample_checker.sv -----
// ----------------------------------------------------------------------------
// pco_sample_checker
// watches both channels of the tone oscillator, predicts every sample from
// its own phase accumulator and rotator, and compares in arrival order
// ----------------------------------------------------------------------------
module pco_sample_checker
  import pco_pkg::*;
#(
  parameter int unsigned PHASE_BITS    = 32,
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [StepW-1:0]              phase_step_i,
  input  logic [AmpW-1:0]               tone_amplitude_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UpShift   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int unsigned DownShift = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int unsigned Stages    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int unsigned SineShift = 31 - SAMPLE_BITS;
  localparam longint QuarterTurn = 64'sd1073741824;
  localparam longint HalfTurn    = 64'sd2147483648;
  localparam longint GainQ30     = 64'sd652032874;
  localparam longint SampleMax   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SampleMin   = -(longint'(1) << (SAMPLE_BITS - 1));

  // atan(2^-i) in 2^-32 turns
  longint atan_turns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [PHASE_BITS-1:0]          tone_phase;
  logic signed [SAMPLE_BITS-1:0]  expected_samples [$];
  logic signed [SAMPLE_BITS-1:0]  oldest_sample;

  // amplitude times sine of the phase, rounded and clipped to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] tone_sample(
    input logic [PHASE_BITS-1:0] phase,
    input logic [AmpW-1:0]       amp
  );
    logic [63:0] wide;
    logic [31:0] turn;
    longint      ang, x, y, x_next, sine, prod;
    int          i;
    wide = 64'(phase);
    turn = 32'((wide >> UpShift) << DownShift);
    ang  = longint'($signed(turn));
    // fold into [-1/4, +1/4] turn
    if (ang > QuarterTurn) ang = HalfTurn - ang;
    else if (ang < -QuarterTurn) ang = -HalfTurn - ang;
    x = GainQ30;
    y = 0;
    for (i = 0; i < Stages; i++) begin
      if (ang >= 0) begin
        x_next = x - (y >>> i);
        y      = y + (x >>> i);
        ang    = ang - atan_turns[i];
      end else begin
        x_next = x + (y >>> i);
        y      = y - (x >>> i);
        ang    = ang + atan_turns[i];
      end
      x = x_next;
    end
    sine = (y + (longint'(1) << (SineShift - 1))) >>> SineShift;
    prod = (longint'(amp) * sine + 16384) >>> 15;
    if (prod > SampleMax) prod = SampleMax;
    if (prod < SampleMin) prod = SampleMin;
    return SAMPLE_BITS'(prod);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] step_wide;
    if (!rst_ni) begin
      tone_phase   <= '0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      expected_samples.delete();
    end else begin
      // retire first so a sample never meets the item taken in this cycle
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample %0d, none pending", $time, sample_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          oldest_sample = expected_samples.pop_front();
          checked_o <= checked_o + 1;
          if (sample_i !== oldest_sample) begin
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, oldest_sample, sample_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // append the prediction at the tail of the queue
        expected_samples = {expected_samples, tone_sample(tone_phase, tone_amplitude_i)};
        step_wide  = (64'(phase_step_i) << UpShift) >> DownShift;
        tone_phase <= tone_phase + step_wide[PHASE_BITS-1:0];
      end
      pending_o <= expected_samples.size();
    end
  end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives tone items into the phase continuous oscillator: a directed pass over
// fold points, saturation and step extremes, then random tones held for runs
// of samples, with bursty input and a patterned output stall
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pco_pkg::*;

  localparam int unsigned PhaseBits    = 32;
  localparam int unsigned SampleBits   = 16;
  localparam int unsigned CordicStages = 16;
  localparam int unsigned ToneItems    = 1700;
  // fold stage + rotator cells + scaling stages, with margin
  localparam int unsigned DrainCycles  = 60;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          out_stall = 1'b0;
  logic [StepW-1:0]              phase_step = '0;
  logic [AmpW-1:0]               tone_amp   = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic signed [SampleBits-1:0]  sample;

  int fail_count, pending, checked;
  int items_sent   = 0;
  int tone_changes = 0;

  // receiver stall pattern state
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;

  phase_continuous_tone_oscillator #(
    .PHASE_BITS   (PhaseBits),
    .SAMPLE_BITS  (SampleBits),
    .CORDIC_STAGES(CordicStages)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .phase_step_i    (phase_step),
    .tone_amplitude_i(tone_amp),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sample_o        (sample)
  );

  pco_sample_checker #(
    .PHASE_BITS   (PhaseBits),
    .SAMPLE_BITS  (SampleBits),
    .CORDIC_STAGES(CordicStages)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .phase_step_i    (phase_step),
    .tone_amplitude_i(tone_amp),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .sample_i        (sample),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d samples still pending", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: switches between free running, sparse random stalls and long
  // stall/release stretches
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) begin
          out_stall = ~out_stall;
          hold_left = $urandom_range(1, 16);
        end
        hold_left--;
      end
    endcase
  end

  // present one item and hold it until taken; returns on the next falling
  // edge with valid still high, so back to back items need no gap
  task automatic push_tone(input logic [StepW-1:0] step, input logic [AmpW-1:0] amp);
    in_valid   = 1'b1;
    phase_step = step;
    tone_amp   = amp;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // step mix: audible tones, plus slow, full range, near nyquist, single-bit
  // and sixteenth-turn multiple steps
  function automatic logic [StepW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return StepW'($urandom_range(0, 32'h3000_0000));
      4, 5:       return StepW'($urandom_range(0, 1 << 20));
      6:          return StepW'($urandom());
      7:          return 31'h7FFF_FFFF - StepW'($urandom_range(0, 1000));
      8:          return StepW'(32'd1 << $urandom_range(0, 30));
      default:    return StepW'(32'h1000_0000 * $urandom_range(0, 7));
    endcase
  endfunction

  // amplitude mix: in range, exact full scale, silence and above full scale
  function automatic logic [AmpW-1:0] pick_amp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return AmpW'($urandom_range(0, 32768));
      6:                return AmpW'(32768);
      7:                return '0;
      8:                return AmpW'($urandom_range(32769, 65535));
      default:          return AmpW'($urandom());
    endcase
  endfunction

  initial begin
    logic [StepW-1:0] run_step;
    logic [AmpW-1:0]  run_amp;
    int run_left, burst, gap;
    run_left = 0;
    run_step = '0;
    run_amp  = '0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // quarter-turn steps land exactly on the fold boundaries, at full scale
    // and then above it so both saturation limits are hit
    repeat (4) push_tone(31'h4000_0000, 16'd32768);
    repeat (4) push_tone(31'h4000_0000, 16'hFFFF);
    // zero step holds the phase, silence and the smallest amplitude
    push_tone('0, '0);
    push_tone('0, 16'd1);
    push_tone(31'd1, 16'hFFFF);
    // largest step, aliased tone
    repeat (3) push_tone(31'h7FFF_FFFF, 16'd32767);
    push_tone(31'h7FFF_FFFF, 16'h8000);
    // eighth-turn steps walk through every octant
    repeat (8) push_tone(31'h2000_0000, 16'h7FFF);
    in_valid = 1'b0;

    // random tones: each one held for a run of samples, phase carried across
    while (items_sent < ToneItems + 22) begin
      burst = $urandom_range(1, 60);
      repeat (burst) begin
        if (run_left == 0) begin
          run_step = pick_step();
          run_amp  = pick_amp();
          run_left = $urandom_range(1, 40);
          tone_changes++;
        end
        // now and then a single stray tick in the middle of a tone
        if ($urandom_range(0, 19) == 0)
          push_tone(pick_step(), pick_amp());
        else
          push_tone(run_step, run_amp);
        run_left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid = 1'b0;
        // idle payload is junk and must be ignored
        phase_step = StepW'($urandom());
        tone_amp   = AmpW'($urandom());
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    // drain, then keep watching for stray samples
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d items over %0d random tones, %0d samples compared",
             items_sent, tone_changes, checked);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pco_pkg.sv
sv/pco_cell.sv
sv/pco_scale.sv
sv/phase_continuous_tone_oscillator.sv
test/pco_sample_checker.sv
test/tb.sv
